>>> sv/assert_macros.svh
// Assertion macros shared by the execute unit RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/mseu_pkg.sv
// Package for the MIPS subset execute unit: opcodes, decode classes,
// decoded-instruction and status structs. No dependencies.
`timescale 1ns / 1ps

package mseu_pkg;

	localparam logic [5:0] OP_RTYPE = 6'b000000;
	localparam logic [5:0] OP_ADDI  = 6'b001000;
	localparam logic [5:0] OP_ADDIU = 6'b001001;
	localparam logic [5:0] OP_J     = 6'b000010;
	localparam logic [5:0] OP_BEQ   = 6'b000100;

	localparam logic [5:0] FN_ADD  = 6'b100000;
	localparam logic [5:0] FN_ADDU = 6'b100001;
	localparam logic [5:0] FN_SUB  = 6'b100010;
	localparam logic [5:0] FN_MULT = 6'b011000;
	localparam logic [5:0] FN_MFLO = 6'b010010;

	localparam logic [31:0] TEXT_BASE_RESET = 32'h0040_0000;

	localparam int NUM_REGS   = 32;
	localparam int REG_ADDR_W = 5;

	// APB register map: one 32-bit register per word
	localparam int PADDR_W   = 3;
	localparam int CFG_IDX_W = PADDR_W - 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE = '0;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		CLS_ADD,
		CLS_SUB,
		CLS_MULT,
		CLS_MFLO,
		CLS_JUMP,
		CLS_BEQ,
		CLS_UNKNOWN
	} cls_t;

	typedef struct packed {
		cls_t                  cls;
		logic [REG_ADDR_W-1:0] rs;
		logic [REG_ADDR_W-1:0] rt;
		logic [REG_ADDR_W-1:0] dest;
		logic                  use_imm;
		logic [31:0]           simm;
		logic [31:0]           jmp_target;
	} dec_t;

	typedef struct packed {
		logic s1_v;
		logic exec_fire;
	} bk_stat_t;

endpackage

>>> sv/mseu_chan_if.sv
// Request channels of the execute unit: instruction in, result out.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps

interface mseu_instr_if #(parameter int INDEX_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [31:0]           instr_word;
	logic [INDEX_BITS-1:0] instr_index;

	modport source(output valid, instr_word, instr_index, input ready);
	modport sink(input valid, instr_word, instr_index, output ready);
endinterface

interface mseu_result_if #(parameter int INDEX_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] next_index;
	logic                  redirect;
	logic                  reg_write;
	logic [4:0]            dest_reg;
	logic [31:0]           write_value;
	logic                  unknown_op;

	modport source(output valid, next_index, redirect, reg_write, dest_reg, write_value,
		unknown_op, input ready);
	modport sink(input valid, next_index, redirect, reg_write, dest_reg, write_value,
		unknown_op, output ready);
endinterface

>>> sv/mseu_front.sv
// Front end: accepts instruction requests, decodes them into a class and
// precomputes fall-through, branch and jump targets. Uses mseu_pkg, mseu_chan_if.
`timescale 1ns / 1ps

module mseu_front import mseu_pkg::*; #(
	parameter int INDEX_BITS = 16
) (
	input  logic                  [31:0] text_base,
	mseu_instr_if.sink                   instr,
	input  logic                         q_ready,
	output logic                         push,
	output dec_t                         dec,
	output logic [INDEX_BITS-1:0]        seq_next,
	output logic [INDEX_BITS-1:0]        br_next
);

	logic [5:0]          op;
	logic [5:0]          fn;
	logic [INDEX_BITS:0] inc;
	logic [31:0]         pc4;

	assign instr.ready = q_ready;
	assign push        = instr.valid && q_ready;

	assign op = instr.instr_word[31:26];
	assign fn = instr.instr_word[5:0];

	assign inc      = {1'b0, instr.instr_index} + (INDEX_BITS + 1)'(1);
	assign seq_next = inc[INDEX_BITS-1:0];
	assign br_next  = inc[INDEX_BITS-1:0] + dec.simm[INDEX_BITS-1:0];
	// byte address of the delay-slot word, source of the jump region bits
	assign pc4      = text_base + 32'({inc, 2'b00});

	always_comb begin
		dec.rs         = instr.instr_word[25:21];
		dec.rt         = instr.instr_word[20:16];
		dec.dest       = instr.instr_word[15:11];
		dec.use_imm    = 1'b0;
		dec.simm       = {{16{instr.instr_word[15]}}, instr.instr_word[15:0]};
		dec.jmp_target = {pc4[31:28], instr.instr_word[25:0], 2'b00};
		dec.cls        = CLS_UNKNOWN;
		unique case (op)
			OP_RTYPE: begin
				unique case (fn)
					FN_ADD, FN_ADDU: dec.cls = CLS_ADD;
					FN_SUB:          dec.cls = CLS_SUB;
					FN_MULT:         dec.cls = CLS_MULT;
					FN_MFLO:         dec.cls = CLS_MFLO;
					default:         dec.cls = CLS_UNKNOWN;
				endcase
			end
			OP_ADDI, OP_ADDIU: begin
				dec.cls     = CLS_ADD;
				dec.use_imm = 1'b1;
				dec.dest    = instr.instr_word[20:16];
			end
			OP_J:    dec.cls = CLS_JUMP;
			OP_BEQ:  dec.cls = CLS_BEQ;
			default: dec.cls = CLS_UNKNOWN;
		endcase
	end

endmodule

>>> sv/mseu_queue.sv
// Short register queue between the front end and the back end.
// Uses mseu_pkg for depth and count widths.
`timescale 1ns / 1ps

module mseu_queue import mseu_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  push_data,
	output logic              ready,
	input  logic              pop,
	output logic              head_valid,
	output logic [WIDTH-1:0]  head_data,
	output logic [QCNT_W-1:0] count
);

	logic [WIDTH-1:0]  ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign ready      = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_data  = ent_q[rd_ptr_q];
	assign count      = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> sv/mseu_back.sv
// Back end: register-file read, execute, write-back and the result
// register. Uses mseu_pkg and mseu_chan_if.
`timescale 1ns / 1ps

module mseu_back import mseu_pkg::*; #(
	parameter int INDEX_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           text_base,
	input  logic                  head_valid,
	input  dec_t                  head_dec,
	input  logic [INDEX_BITS-1:0] head_seq_next,
	input  logic [INDEX_BITS-1:0] head_br_next,
	output logic                  pop,
	mseu_result_if.source         result,
	output bk_stat_t              stat
);

	// register file: memory plus per-entry valid bits so reset reads as zero
	logic [31:0]           rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0]   rf_vld_q;

	// read stage
	logic                  v_s1;
	dec_t                  dec_s1;
	logic [INDEX_BITS-1:0] seq_s1;
	logic [INDEX_BITS-1:0] br_s1;
	logic [31:0]           ra_s1;
	logic [31:0]           rb_s1;

	// most recent write, covers the write that lands on the read edge
	logic                  lw_v_q;
	logic [REG_ADDR_W-1:0] lw_addr_q;
	logic [31:0]           lw_data_q;

	logic [31:0]           lo_q;

	logic                  out_v_q;
	logic [INDEX_BITS-1:0] next_q;
	logic                  redir_q;
	logic                  wr_q;
	logic [REG_ADDR_W-1:0] dest_q;
	logic [31:0]           val_q;
	logic                  unk_q;

	logic                  exec_fire;
	logic                  rf_we;
	logic [31:0]           opa;
	logic [31:0]           opb;
	logic [31:0]           alu_b;
	logic [31:0]           prod_lo;
	logic [31:0]           jdiff;
	logic [INDEX_BITS-1:0] ex_next;
	logic                  ex_redir;
	logic                  ex_wr;
	logic [31:0]           ex_val;
	logic                  ex_unk;
	logic                  ex_lo_we;

	assign exec_fire = v_s1 && (!out_v_q || result.ready);
	assign pop       = head_valid && (!v_s1 || exec_fire);
	assign rf_we     = exec_fire && ex_wr && (dec_s1.dest != '0);

	assign stat.s1_v      = v_s1;
	assign stat.exec_fire = exec_fire;

	always_comb begin
		priority if (dec_s1.rs == '0)                        opa = '0;
		else if (lw_v_q && (lw_addr_q == dec_s1.rs))         opa = lw_data_q;
		else if (rf_vld_q[dec_s1.rs])                        opa = ra_s1;
		else                                                 opa = '0;
		priority if (dec_s1.rt == '0)                        opb = '0;
		else if (lw_v_q && (lw_addr_q == dec_s1.rt))         opb = lw_data_q;
		else if (rf_vld_q[dec_s1.rt])                        opb = rb_s1;
		else                                                 opb = '0;
	end

	assign alu_b   = dec_s1.use_imm ? dec_s1.simm : opb;
	assign prod_lo = opa * opb;
	assign jdiff   = dec_s1.jmp_target - text_base;

	always_comb begin
		ex_next  = seq_s1;
		ex_redir = 1'b0;
		ex_wr    = 1'b0;
		ex_val   = '0;
		ex_unk   = 1'b0;
		ex_lo_we = 1'b0;
		unique case (dec_s1.cls)
			CLS_ADD: begin
				ex_wr  = 1'b1;
				ex_val = opa + alu_b;
			end
			CLS_SUB: begin
				ex_wr  = 1'b1;
				ex_val = opa - opb;
			end
			CLS_MULT: ex_lo_we = 1'b1;
			CLS_MFLO: begin
				ex_wr  = 1'b1;
				ex_val = lo_q;
			end
			CLS_JUMP: begin
				ex_next  = jdiff[INDEX_BITS+1:2];
				ex_redir = 1'b1;
			end
			CLS_BEQ: begin
				if (opa == opb) begin
					ex_next  = br_s1;
					ex_redir = 1'b1;
				end
			end
			default: ex_unk = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			out_v_q  <= 1'b0;
			rf_vld_q <= '0;
			lw_v_q   <= 1'b0;
			lo_q     <= '0;
		end else begin
			if (pop)            v_s1 <= 1'b1;
			else if (exec_fire) v_s1 <= 1'b0;
			if (exec_fire)         out_v_q <= 1'b1;
			else if (result.ready) out_v_q <= 1'b0;
			if (rf_we) begin
				rf_vld_q[dec_s1.dest] <= 1'b1;
				lw_v_q                <= 1'b1;
			end
			if (exec_fire && ex_lo_we) lo_q <= prod_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[dec_s1.dest] <= ex_val;
		if (pop) begin
			ra_s1  <= rf_mem[head_dec.rs];
			rb_s1  <= rf_mem[head_dec.rt];
			dec_s1 <= head_dec;
			seq_s1 <= head_seq_next;
			br_s1  <= head_br_next;
		end
		if (rf_we) begin
			lw_addr_q <= dec_s1.dest;
			lw_data_q <= ex_val;
		end
		if (exec_fire) begin
			next_q  <= ex_next;
			redir_q <= ex_redir;
			wr_q    <= ex_wr;
			dest_q  <= ex_wr ? dec_s1.dest : '0;
			val_q   <= ex_wr ? ex_val : '0;
			unk_q   <= ex_unk;
		end
	end

	assign result.valid       = out_v_q;
	assign result.next_index  = next_q;
	assign result.redirect    = redir_q;
	assign result.reg_write   = wr_q;
	assign result.dest_reg    = dest_q;
	assign result.write_value = val_q;
	assign result.unknown_op  = unk_q;

endmodule

>>> sv/mips_subset_execute_unit_core.sv
// MIPS subset execute unit (add, addu, sub, mult, mflo, addi, addiu, j, beq),
// built on mseu_pkg, mseu_chan_if, mseu_front, mseu_queue, mseu_back and
// assert_macros.svh. Each accepted instruction request yields exactly one
// result request, in order. The unit sustains one instruction per clock while
// the result side accepts: the front end decodes into a two-entry queue, the
// back end reads the register file (registered read) and executes once the
// result register is free, with a one-deep bypass from the latest write. An
// accepted request passes the queue, the read stage and the result register.
// The register file clears at reset through valid bits and LO by reset, so
// there is no clearing pass. text_base sits at APB byte address 0; the user must
// see that it is written only while the unit is idle, the unit does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mips_subset_execute_unit_core import mseu_pkg::*; #(
	parameter int INDEX_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	mseu_instr_if.sink         instr,
	mseu_result_if.source      result
);

	localparam int QW = $bits(dec_t) + 2 * INDEX_BITS;

	logic [31:0]           text_base_q;
	logic [CFG_IDX_W-1:0]  cfg_idx;

	logic                  push;
	dec_t                  fr_dec;
	logic [INDEX_BITS-1:0] fr_seq;
	logic [INDEX_BITS-1:0] fr_br;
	logic                  q_ready;
	logic                  q_pop;
	logic                  q_valid;
	logic [QW-1:0]         q_head;
	logic [QCNT_W-1:0]     q_cnt;
	dec_t                  hd_dec;
	logic [INDEX_BITS-1:0] hd_seq;
	logic [INDEX_BITS-1:0] hd_br;
	bk_stat_t              bk_stat;

	assign cfg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = (cfg_idx == CFG_TEXT_BASE) ? text_base_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_base_q <= TEXT_BASE_RESET;
		end else if (psel && penable && pwrite && (cfg_idx == CFG_TEXT_BASE)) begin
			text_base_q <= pwdata;
		end
	end

	mseu_front #(.INDEX_BITS(INDEX_BITS)) u_front (
		.text_base (text_base_q),
		.instr     (instr),
		.q_ready   (q_ready),
		.push      (push),
		.dec       (fr_dec),
		.seq_next  (fr_seq),
		.br_next   (fr_br)
	);

	mseu_queue #(.WIDTH(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({fr_dec, fr_seq, fr_br}),
		.ready      (q_ready),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_head),
		.count      (q_cnt)
	);

	assign {hd_dec, hd_seq, hd_br} = q_head;

	mseu_back #(.INDEX_BITS(INDEX_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_base     (text_base_q),
		.head_valid    (q_valid),
		.head_dec      (hd_dec),
		.head_seq_next (hd_seq),
		.head_br_next  (hd_br),
		.pop           (q_pop),
		.result        (result),
		.stat          (bk_stat)
	);

	`ASSERT_ALWAYS(a_queue_bound, clk, arst_n, q_cnt <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
	`ASSERT_NEXT(a_queue_drains, clk, arst_n, (q_cnt != '0) && !bk_stat.s1_v, bk_stat.s1_v, "queued request not issued")
	`ASSERT_NEXT(a_exec_to_out, clk, arst_n, bk_stat.exec_fire, result.valid, "executed request missing at output")
	`ASSERT_SAME(a_out_source, clk, arst_n, $rose(result.valid), $past(bk_stat.s1_v), "result without an executing request")

endmodule

>>> tb/testbench.sv
// Self-checking bench for mips_subset_execute_unit_core: directed table then random programs,
// checked against an in-bench instruction predictor. Depends on mseu_pkg, mseu_chan_if.
`timescale 1ns / 1ps

module testbench;
	import mseu_pkg::*;

	localparam int INDEX_BITS      = 16;
	localparam int NUM_PHASES      = 7;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int CYCLE_LIMIT     = 200000;

	localparam logic [5:0]           FN_UNUSED    = 6'b111111;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_TEXT_BASE + 1'b1;

	typedef struct packed {
		logic [INDEX_BITS-1:0] next_index;
		logic                  redirect;
		logic                  reg_write;
		logic [4:0]            dest_reg;
		logic [31:0]           write_value;
		logic                  unknown_op;
	} exec_res_t;

	typedef struct {
		logic [31:0]           word;
		logic [INDEX_BITS-1:0] idx;
		bit                    typed;
		exec_res_t             res;
	} instr_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mseu_instr_if  #(.INDEX_BITS(INDEX_BITS)) instr_ch();
	mseu_result_if #(.INDEX_BITS(INDEX_BITS)) res_ch();

	mips_subset_execute_unit_core #(.INDEX_BITS(INDEX_BITS)) DUT (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.instr(instr_ch), .result(res_ch)
	);

	// predictor state
	logic [31:0] gpr [NUM_REGS];
	logic [31:0] lo_reg;
	logic [31:0] text_base_cur;

	exec_res_t             exec_results_due[$];
	instr_row_t            directed_reqs[$];
	logic [INDEX_BITS-1:0] next_fetch;
	bit                    cur_typed;
	exec_res_t             cur_typed_res;
	int unsigned           stall_pct;
	int unsigned           ready_hold;
	int unsigned           mismatches;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic exec_res_t mk_res(logic [INDEX_BITS-1:0] nx, logic redir, logic wr,
			logic [4:0] dst, logic [31:0] val, logic unk);
		exec_res_t r;
		r.next_index  = nx;
		r.redirect    = redir;
		r.reg_write   = wr;
		r.dest_reg    = dst;
		r.write_value = val;
		r.unknown_op  = unk;
		return r;
	endfunction

	// executes one instruction on the bench copy of the architectural state
	function automatic exec_res_t execute_instr(logic [31:0] w, logic [INDEX_BITS-1:0] idx);
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd;
		logic [31:0] simm, a, b, nxt, pc4, tgt;
		exec_res_t   r;
		op   = w[31:26];
		rs   = w[25:21];
		rt   = w[20:16];
		rd   = w[15:11];
		fn   = w[5:0];
		simm = {{16{w[15]}}, w[15:0]};
		a    = (rs == 5'd0) ? 32'd0 : gpr[rs];
		b    = (rt == 5'd0) ? 32'd0 : gpr[rt];
		nxt  = 32'(idx) + 32'd1;
		r    = '0;
		case (op)
			OP_RTYPE: begin
				case (fn)
					FN_ADD, FN_ADDU: begin
						r.reg_write = 1'b1; r.dest_reg = rd; r.write_value = a + b;
					end
					FN_SUB: begin
						r.reg_write = 1'b1; r.dest_reg = rd; r.write_value = a - b;
					end
					FN_MULT: lo_reg = a * b;
					FN_MFLO: begin
						r.reg_write = 1'b1; r.dest_reg = rd; r.write_value = lo_reg;
					end
					default: r.unknown_op = 1'b1;
				endcase
			end
			OP_ADDI, OP_ADDIU: begin
				r.reg_write = 1'b1; r.dest_reg = rt; r.write_value = a + simm;
			end
			OP_J: begin
				pc4 = text_base_cur + (nxt << 2);
				tgt = {pc4[31:28], w[25:0], 2'b00};
				nxt = (tgt - text_base_cur) >> 2;
				r.redirect = 1'b1;
			end
			OP_BEQ: begin
				if (a == b) begin
					nxt = nxt + simm;
					r.redirect = 1'b1;
				end
			end
			default: r.unknown_op = 1'b1;
		endcase
		if (r.reg_write && r.dest_reg != 5'd0)
			gpr[r.dest_reg] = r.write_value;
		r.next_index = nxt[INDEX_BITS-1:0];
		return r;
	endfunction

	function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd, logic [4:0] sh);
		return {OP_RTYPE, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] enc_j(logic [25:0] t);
		return {OP_J, t};
	endfunction

	// low registers most of the time so that values chain through dependencies
	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom);
	endfunction

	function automatic logic [31:0] rand_instr();
		int unsigned sel;
		logic [5:0]  code;
		logic [4:0]  rs, rt;
		sel = $urandom_range(0, 99);
		rs  = pick_reg();
		rt  = pick_reg();
		if (sel < 12)
			return enc_r(FN_ADD, rs, rt, pick_reg(), 5'($urandom));
		else if (sel < 22)
			return enc_r(FN_ADDU, rs, rt, pick_reg(), 5'($urandom));
		else if (sel < 32)
			return enc_r(FN_SUB, rs, rt, pick_reg(), 5'($urandom));
		else if (sel < 42)
			return enc_r(FN_MULT, rs, rt, 5'($urandom), 5'($urandom));
		else if (sel < 52)
			return enc_r(FN_MFLO, 5'($urandom), 5'($urandom), pick_reg(), 5'($urandom));
		else if (sel < 64)
			return enc_i(OP_ADDI, rs, rt, 16'($urandom));
		else if (sel < 74)
			return enc_i(OP_ADDIU, rs, rt, 16'($urandom));
		else if (sel < 84) begin
			if ($urandom_range(0, 9) < 4)
				rt = rs;
			return enc_i(OP_BEQ, rs, rt, 16'($urandom));
		end else if (sel < 90)
			return enc_j(26'($urandom));
		else if (sel < 94) begin
			do
				code = 6'($urandom);
			while (code == FN_ADD || code == FN_ADDU || code == FN_SUB ||
				code == FN_MULT || code == FN_MFLO);
			return enc_r(code, rs, rt, pick_reg(), 5'($urandom));
		end else if (sel < 97) begin
			do
				code = 6'($urandom);
			while (code == OP_RTYPE || code == OP_ADDI || code == OP_ADDIU ||
				code == OP_J || code == OP_BEQ);
			return {code, 26'($urandom)};
		end
		return $urandom;
	endfunction

	task automatic add_row(logic [31:0] word, logic [INDEX_BITS-1:0] idx, bit typed,
			exec_res_t res);
		instr_row_t row;
		row.word  = word;
		row.idx   = idx;
		row.typed = typed;
		row.res   = res;
		directed_reqs.insert(directed_reqs.size(), row);
	endtask

	// one instruction request; follow = take the predicted fetch index
	task automatic send_instr(logic [31:0] word, logic [INDEX_BITS-1:0] idx, bit follow,
			bit typed, exec_res_t res);
		int unsigned gap;
		gap = ($urandom_range(0, 99) < stall_pct) ? $urandom_range(1, 4) : 0;
		@(negedge clk);
		if (gap != 0) begin
			instr_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		instr_ch.instr_word  = word;
		instr_ch.instr_index = follow ? next_fetch : idx;
		cur_typed            = typed;
		cur_typed_res        = res;
		instr_ch.valid       = 1'b1;
		do
			@(posedge clk);
		while (!instr_ch.ready);
	endtask

	task automatic end_burst();
		@(negedge clk);
		instr_ch.valid = 1'b0;
		cur_typed      = 1'b0;
	endtask

	task automatic apb_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx == CFG_TEXT_BASE)
			text_base_cur = data;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic apb_read(logic [CFG_IDX_W-1:0] idx, output logic [31:0] data);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		data = prdata;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
	endtask

	task automatic drain();
		while (exec_results_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// result sink: random stall bursts on ready
	always @(negedge clk) begin
		if (ready_hold != 0) begin
			ready_hold--;
			res_ch.ready = 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			res_ch.ready = 1'b0;
			ready_hold   = $urandom_range(0, 3);
		end else begin
			res_ch.ready = 1'b1;
		end
	end

	// predict on each accepted instruction, then check each accepted result
	always @(posedge clk) begin
		exec_res_t e, g;
		string     bad;
		if (arst_n) begin
			if (instr_ch.valid && instr_ch.ready) begin
				e = execute_instr(instr_ch.instr_word, instr_ch.instr_index);
				if (cur_typed)
					e = cur_typed_res;
				next_fetch = e.next_index;
				exec_results_due.insert(exec_results_due.size(), e);
			end
			if (res_ch.valid && res_ch.ready) begin
				g = mk_res(res_ch.next_index, res_ch.redirect, res_ch.reg_write,
					res_ch.dest_reg, res_ch.write_value, res_ch.unknown_op);
				if (exec_results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result request with none outstanding: %p", $realtime, g);
				end else begin
					e   = exec_results_due.pop_front();
					bad = "";
					if (g.next_index !== e.next_index)   bad = {bad, " next_index"};
					if (g.redirect !== e.redirect)       bad = {bad, " redirect"};
					if (g.reg_write !== e.reg_write)     bad = {bad, " reg_write"};
					if (g.dest_reg !== e.dest_reg)       bad = {bad, " dest_reg"};
					if (g.write_value !== e.write_value) bad = {bad, " write_value"};
					if (g.unknown_op !== e.unknown_op)   bad = {bad, " unknown_op"};
					if (bad != "") begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch on%s", $realtime, bad);
							$display("  exp next=%h redir=%b wr=%b rd=%0d val=%h unk=%b",
								e.next_index, e.redirect, e.reg_write, e.dest_reg,
								e.write_value, e.unknown_op);
							$display("  got next=%h redir=%b wr=%b rd=%0d val=%h unk=%b",
								g.next_index, g.redirect, g.reg_write, g.dest_reg,
								g.write_value, g.unknown_op);
						end
					end
				end
			end
		end
	end

	initial begin
		logic [31:0]  rb;
		logic [31:0]  base_sel [NUM_PHASES];
		int unsigned  pct_sel [NUM_PHASES];
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		instr_ch.valid = 1'b0; instr_ch.instr_word = '0; instr_ch.instr_index = '0;
		res_ch.ready = 1'b0;
		ready_hold = 0; mismatches = 0; next_fetch = '0;
		cur_typed = 1'b0; cur_typed_res = '0; stall_pct = 20;
		foreach (gpr[i])
			gpr[i] = '0;
		lo_reg        = '0;
		text_base_cur = TEXT_BASE_RESET;

		base_sel = '{TEXT_BASE_RESET, 32'h0000_0000, 32'hFFFF_FFFF, $urandom,
			32'h8000_0000, $urandom & 32'hFFFF_FFFC, TEXT_BASE_RESET};
		pct_sel  = '{20, 0, 40, 10, 60, 25, 0};

		// state just out of reset, immediate extremes, overflow chains, flow control, unknown opcodes
		add_row(enc_r(FN_ADDU, 0, 0, 1, 0), 0, 1, mk_res(1, 0, 1, 1, 0, 0));
		add_row(enc_r(FN_ADD, 5, 6, 2, 0), 1, 1, mk_res(2, 0, 1, 2, 0, 0));
		add_row(enc_r(FN_MFLO, 0, 0, 3, 0), 2, 1, mk_res(3, 0, 1, 3, 0, 0));
		add_row(enc_i(OP_ADDI, 0, 2, 16'h7FFF), 3, 1, mk_res(4, 0, 1, 2, 32'h0000_7FFF, 0));
		add_row(enc_i(OP_ADDI, 0, 3, 16'h8000), 4, 1, mk_res(5, 0, 1, 3, 32'hFFFF_8000, 0));
		add_row(enc_i(OP_ADDIU, 0, 4, 16'hFFFF), 5, 1, mk_res(6, 0, 1, 4, 32'hFFFF_FFFF, 0));
		add_row(enc_r(FN_SUB, 0, 3, 7, 0), 6, 0, '0);
		add_row(enc_r(FN_MULT, 3, 7, 9, 5'h1F), 7, 0, '0);
		add_row(enc_r(FN_MFLO, 0, 0, 9, 0), 8, 0, '0);
		add_row(enc_r(FN_ADD, 9, 9, 9, 0), 9, 0, '0);
		add_row(enc_r(FN_SUB, 9, 2, 10, 0), 10, 0, '0);
		add_row(enc_r(FN_ADD, 4, 4, 0, 0), 11, 0, '0);
		add_row(enc_r(FN_ADD, 0, 4, 11, 0), 12, 0, '0);
		add_row(enc_r(FN_MULT, 4, 4, 0, 0), 13, 0, '0);
		add_row(enc_r(FN_MFLO, 0, 0, 12, 5'h10), 14, 0, '0);
		add_row(enc_i(OP_BEQ, 0, 0, 16'hFFFE), 0, 1, mk_res(16'hFFFF, 1, 0, 0, 0, 0));
		add_row(enc_i(OP_BEQ, 0, 0, 16'h0000), 16'hFFFF, 1, mk_res(0, 1, 0, 0, 0, 0));
		add_row(enc_i(OP_BEQ, 4, 0, 16'h7FFF), 100, 0, '0);
		add_row(enc_i(OP_BEQ, 3, 3, 16'h7FFF), 200, 0, '0);
		add_row(enc_j(26'h010_0005), 20, 1, mk_res(5, 1, 0, 0, 0, 0));
		add_row(enc_j(26'h000_0000), 21, 0, '0);
		add_row(enc_j(26'h3FF_FFFF), 16'hFFFF, 0, '0);
		add_row(32'hFFFF_FFFF, 30, 1, mk_res(31, 0, 0, 0, 0, 1));
		add_row(enc_r(FN_UNUSED, 31, 31, 31, 31), 16'hFFFF, 1, mk_res(0, 0, 0, 0, 0, 1));
		add_row(32'h0000_0000, 40, 1, mk_res(41, 0, 0, 0, 0, 1));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_reqs[i])
			send_instr(directed_reqs[i].word, directed_reqs[i].idx, 1'b0,
				directed_reqs[i].typed, directed_reqs[i].res);
		end_burst();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p != 0) begin
				drain();
				apb_write(CFG_TEXT_BASE, base_sel[p]);
				if (p == 3)
					apb_write(CFG_UNMAPPED, $urandom);
				apb_read(CFG_TEXT_BASE, rb);
				if (rb !== text_base_cur) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: text_base read back %h, expected %h",
							$realtime, rb, text_base_cur);
				end
			end
			stall_pct = pct_sel[p];
			// random programs that mostly follow the predicted flow
			repeat (ITEMS_PER_PHASE)
				send_instr(rand_instr(), 16'($urandom), $urandom_range(0, 99) < 85, 1'b0, '0);
			end_burst();
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && exec_results_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> mips_subset_execute_unit_core.f
+incdir+sv
sv/mseu_pkg.sv
sv/mseu_chan_if.sv
sv/mseu_front.sv
sv/mseu_queue.sv
sv/mseu_back.sv
sv/mips_subset_execute_unit_core.sv
tb/testbench.sv
